### hdl/clex_pkg.sv
// Package for the C subset lexer: transaction types, token kind codes,
// keyword table and byte classification helpers.
// Used by every module under hdl; depends on nothing.
package clex_pkg;

  localparam int KEYWORD_BYTES_DFLT = 6;
  localparam int LENGTH_BITS_DFLT   = 8;
  localparam int POSITION_BITS_DFLT = 32;

  localparam int KW_COUNT   = 9;
  localparam int KW_MAX_LEN = 6;

  typedef logic [4:0]  token_kind_t;
  typedef logic [31:0] token_start_t;
  typedef logic [7:0]  token_length_t;
  typedef logic [7:0]  char_t;

  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_EOF  = 1'b1;

  localparam token_kind_t KIND_IDENT   = 5'd0;
  localparam token_kind_t KIND_NUMBER  = 5'd1;
  localparam token_kind_t KIND_INT     = 5'd2;
  localparam token_kind_t KIND_FLOAT   = 5'd3;
  localparam token_kind_t KIND_CHAR    = 5'd4;
  localparam token_kind_t KIND_VOID    = 5'd5;
  localparam token_kind_t KIND_RETURN  = 5'd6;
  localparam token_kind_t KIND_IF      = 5'd7;
  localparam token_kind_t KIND_ELSE    = 5'd8;
  localparam token_kind_t KIND_WHILE   = 5'd9;
  localparam token_kind_t KIND_FOR     = 5'd10;
  localparam token_kind_t KIND_PLUS    = 5'd11;
  localparam token_kind_t KIND_MINUS   = 5'd12;
  localparam token_kind_t KIND_STAR    = 5'd13;
  localparam token_kind_t KIND_SLASH   = 5'd14;
  localparam token_kind_t KIND_LPAREN  = 5'd15;
  localparam token_kind_t KIND_RPAREN  = 5'd16;
  localparam token_kind_t KIND_ASSIGN  = 5'd17;
  localparam token_kind_t KIND_SEMI    = 5'd18;
  localparam token_kind_t KIND_LBRACE  = 5'd19;
  localparam token_kind_t KIND_RBRACE  = 5'd20;
  localparam token_kind_t KIND_EOF     = 5'd21;
  localparam token_kind_t KIND_UNKNOWN = 5'd22;

  localparam char_t CHAR_UNDERSCORE = 8'h5F;

  typedef struct packed {
    logic  req_type;
    char_t char_code;
  } lex_in_t;

  typedef struct packed {
    token_kind_t   token_kind;
    token_start_t  token_start;
    token_length_t token_length;
    logic          last;
  } lex_out_t;

  // Up to two results produced by one input transaction, in order.
  typedef struct packed {
    logic [1:0] count;
    lex_out_t   first;
    lex_out_t   second;
  } scan_res_t;

  localparam char_t KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t", 8'h00},
    '{"c", "h", "a", "r", 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n"},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd5, 3'd4, 3'd4, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3
  };

  localparam token_kind_t KW_KIND [KW_COUNT] = '{
    KIND_INT, KIND_FLOAT, KIND_CHAR, KIND_VOID, KIND_RETURN,
    KIND_IF, KIND_ELSE, KIND_WHILE, KIND_FOR
  };

  function automatic logic is_digit(input char_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input char_t c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_space(input char_t c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic token_kind_t punct_kind(input char_t c);
    token_kind_t kind;
    unique case (c)
      "+":     kind = KIND_PLUS;
      "-":     kind = KIND_MINUS;
      "*":     kind = KIND_STAR;
      "/":     kind = KIND_SLASH;
      "(":     kind = KIND_LPAREN;
      ")":     kind = KIND_RPAREN;
      "=":     kind = KIND_ASSIGN;
      ";":     kind = KIND_SEMI;
      "{":     kind = KIND_LBRACE;
      "}":     kind = KIND_RBRACE;
      default: kind = KIND_UNKNOWN;
    endcase
    return kind;
  endfunction

  // A length of zero means the identifier is too long to be a keyword.
  function automatic token_kind_t kw_kind(input logic [8*KW_MAX_LEN-1:0] bytes,
                                          input logic [2:0] len);
    token_kind_t kind;
    logic        hit;
    kind = KIND_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      hit = (len == KW_LEN[i]);
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if ((3'(j) < KW_LEN[i]) && (bytes[8*j +: 8] != KW_TEXT[i][j])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kind = KW_KIND[i];
      end
    end
    return kind;
  endfunction

endpackage

### hdl/clex_scan.sv
// Scanner core: run state, identifier prefix store and token formation for
// the transaction held in the input register. Depends on clex_pkg.
module clex_scan #(
  parameter int KEYWORD_BYTES = clex_pkg::KEYWORD_BYTES_DFLT,
  parameter int LENGTH_BITS   = clex_pkg::LENGTH_BITS_DFLT,
  parameter int POSITION_BITS = clex_pkg::POSITION_BITS_DFLT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_vld,
  input  clex_pkg::lex_in_t   item,
  input  logic                commit,
  output clex_pkg::scan_res_t scan_o
);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_IDENT  = 3'b010,
    MODE_NUMBER = 3'b100
  } scan_mode_t;

  scan_mode_t               mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [LENGTH_BITS-1:0]   len_r, len_nxt;
  clex_pkg::char_t          prefix_r [KEYWORD_BYTES];

  clex_pkg::char_t                          c;
  logic                                     eof;
  logic                                     digit;
  logic                                     word;
  logic                                     space;
  logic                                     extend;
  logic                                     close_fire;
  logic                                     other_fire;
  logic                                     wr_en;
  logic [LENGTH_BITS-1:0]                   wr_idx;
  logic [8*clex_pkg::KW_MAX_LEN-1:0]        kw_bytes;
  logic [2:0]                               kw_len;
  clex_pkg::lex_out_t                       close_res;
  clex_pkg::lex_out_t                       other_res;

  always_comb begin
    c      = item.char_code;
    eof    = (item.req_type == clex_pkg::REQ_EOF);
    digit  = clex_pkg::is_digit(c);
    word   = digit || clex_pkg::is_alpha(c) || (c == clex_pkg::CHAR_UNDERSCORE);
    space  = clex_pkg::is_space(c);
    extend = !eof && (((mode_r == MODE_IDENT) && word) ||
                      ((mode_r == MODE_NUMBER) && digit));

    for (int j = 0; j < clex_pkg::KW_MAX_LEN; j++) begin
      kw_bytes[8*j +: 8] = prefix_r[j];
    end
    kw_len = (len_r <= LENGTH_BITS'(clex_pkg::KW_MAX_LEN)) ? len_r[2:0] : 3'd0;

    close_fire = (mode_r != MODE_IDLE) && !extend;
    other_fire = eof || (!extend && !space && !word);

    close_res.token_kind   = (mode_r == MODE_IDENT) ?
                             clex_pkg::kw_kind(kw_bytes, kw_len) : clex_pkg::KIND_NUMBER;
    close_res.token_start  = clex_pkg::token_start_t'(start_r);
    close_res.token_length = clex_pkg::token_length_t'(len_r);
    close_res.last         = !other_fire;

    other_res.token_kind   = eof ? clex_pkg::KIND_EOF : clex_pkg::punct_kind(c);
    other_res.token_start  = clex_pkg::token_start_t'(pos_r);
    other_res.token_length = eof ? 8'd0 : 8'd1;
    other_res.last         = 1'b1;

    scan_o.count  = item_vld ? ({1'b0, close_fire} + {1'b0, other_fire}) : 2'd0;
    scan_o.first  = close_fire ? close_res : other_res;
    scan_o.second = other_res;

    mode_nxt  = mode_r;
    pos_nxt   = pos_r + POSITION_BITS'(1);
    start_nxt = start_r;
    len_nxt   = len_r;
    wr_en     = 1'b0;
    wr_idx    = len_r;
    if (eof) begin
      mode_nxt = MODE_IDLE;
      pos_nxt  = '0;
      len_nxt  = '0;
    end else if (extend) begin
      wr_en = 1'b1;
      if (len_r != '1) begin
        len_nxt = len_r + LENGTH_BITS'(1);
      end
    end else begin
      mode_nxt = MODE_IDLE;
      if (word) begin
        mode_nxt  = digit ? MODE_NUMBER : MODE_IDENT;
        start_nxt = pos_r;
        len_nxt   = LENGTH_BITS'(1);
        wr_en     = 1'b1;
        wr_idx    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
    end else if (commit) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
    end
  end

  // Only the first KEYWORD_BYTES bytes of an identifier are kept.
  always_ff @(posedge clk) begin
    for (int i = 0; i < KEYWORD_BYTES; i++) begin
      if (commit && wr_en && (wr_idx == LENGTH_BITS'(i))) begin
        prefix_r[i] <= c;
      end
    end
  end

`ifndef SYNTH
  a_open_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_IDLE) |-> (len_r != '0))
    else $error("open run with zero length");

  a_eof_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && eof) |=> ((pos_r == '0) && (mode_r == MODE_IDLE)))
    else $error("end of input did not rewind the scanner");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_o.count == 2'd2) |-> (!scan_o.first.last && scan_o.second.last))
    else $error("last flag misplaced on a two-token transaction");
`endif

endmodule

### hdl/clex_obuf.sv
// Two-entry result buffer: takes up to two tokens per transaction and
// presents them one per cycle on the result channel while out_stall is low. Depends on clex_pkg.
module clex_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  clex_pkg::scan_res_t scan_i,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output clex_pkg::lex_out_t  out_data
);

  logic [1:0]         cnt_r, cnt_nxt;
  clex_pkg::lex_out_t s0_r, s0_nxt;
  clex_pkg::lex_out_t s1_r, s1_nxt;

  logic               pop;
  logic [1:0]         cnt_rem;
  logic [1:0]         push_n;

  always_comb begin
    pop     = (cnt_r != 2'd0) && !out_stall;
    cnt_rem = cnt_r - {1'b0, pop};
    room    = ({1'b0, cnt_rem} + {1'b0, scan_i.count}) <= 3'd2;
    push_n  = room ? scan_i.count : 2'd0;
    cnt_nxt = cnt_rem + push_n;

    // Survivors stay in front; new tokens fill in behind them.
    s0_nxt = (cnt_rem != 2'd0) ? (pop ? s1_r : s0_r) : scan_i.first;
    priority if (cnt_rem == 2'd2) begin
      s1_nxt = s1_r;
    end else if (cnt_rem == 2'd1) begin
      s1_nxt = scan_i.first;
    end else begin
      s1_nxt = scan_i.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = s0_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer overfilled");
`endif

endmodule

### hdl/c_subset_lexer.sv
// Byte-serial lexer for a small C subset: one byte or end mark per transaction.
// A transaction is held in the input register, its tokens in the result buffer.
// Throughput: one transaction per cycle unless in_stall; the result port moves
// one token per cycle unless out_stall, so a two-token transaction can hold the input once tokens queue.
// Reset (rst_n low, synchronous) empties all stages and rewinds the scanner;
// the identifier prefix store is not cleared.
module c_subset_lexer #(
  parameter int KEYWORD_BYTES = clex_pkg::KEYWORD_BYTES_DFLT,
  parameter int LENGTH_BITS   = clex_pkg::LENGTH_BITS_DFLT,
  parameter int POSITION_BITS = clex_pkg::POSITION_BITS_DFLT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  clex_pkg::lex_in_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output clex_pkg::lex_out_t out_data
);

  logic                in_vld_r;
  clex_pkg::lex_in_t   in_item_r;
  logic                room;
  logic                commit;
  logic                take;
  clex_pkg::scan_res_t scan_res;

  assign commit   = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (take) begin
      in_vld_r <= 1'b1;
    end else if (commit) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_item_r <= in_data;
    end
  end

  clex_scan #(
    .KEYWORD_BYTES (KEYWORD_BYTES),
    .LENGTH_BITS   (LENGTH_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (in_vld_r),
    .item     (in_item_r),
    .commit   (commit),
    .scan_o   (scan_res)
  );

  clex_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .scan_i    (scan_res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
